@@ rtl/core/gtg_pkg.sv @@
package gtg_pkg;

    localparam int POS_W      = 16;
    localparam int HEAD_W     = 15;
    localparam int DELTA_W    = 17;
    localparam int XY_W       = 28;
    localparam int Z_W        = 20;
    localparam int VAL_W      = 34;
    localparam int DIST_W     = 17;
    localparam int SQRT_STEPS = 17;
    localparam int ANG_FRAC   = 16;
    localparam int GUARD_SH   = 8;
    localparam int ATAN_IDX_W = 5;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SPEED_W    = 16;
    localparam int TURN_W     = 15;
    localparam int ERR_W      = 24;
    localparam int FRONT_ST   = 3;
    localparam int BACK_ST    = 3;

    localparam logic signed [Z_W-1:0] PI_Q16   = Z_W'(205887);
    localparam logic [TURN_W-1:0]     TURN_SAT = '1;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd3;

    typedef struct packed {
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic [VAL_W-1:0]         rem;
        logic [DIST_W-1:0]        root;
        logic signed [HEAD_W-1:0] heading;
    } cell_data_t;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            5'd0:    a = Z_W'(51472);
            5'd1:    a = Z_W'(30385);
            5'd2:    a = Z_W'(16055);
            5'd3:    a = Z_W'(8150);
            5'd4:    a = Z_W'(4091);
            5'd5:    a = Z_W'(2047);
            5'd6:    a = Z_W'(1024);
            5'd7:    a = Z_W'(512);
            5'd8:    a = Z_W'(256);
            5'd9:    a = Z_W'(128);
            5'd10:   a = Z_W'(64);
            5'd11:   a = Z_W'(32);
            5'd12:   a = Z_W'(16);
            5'd13:   a = Z_W'(8);
            5'd14:   a = Z_W'(4);
            5'd15:   a = Z_W'(2);
            5'd16:   a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/core/go_to_goal_velocity_controller_unit.sv @@
// Go-to-goal velocity controller: one pose beat in, one velocity command beat out.
// The s_ channel carries a pose (x, y, heading); the m_ channel returns linear
// speed and turn rate for that pose, in the order the poses were accepted.
// The goal point, speed gain and speed limit are written through the cfg_ port,
// by the user only while no beat is in flight, which the block does not enforce;
// a write takes effect at the clock edge it is given.
// Throughput is one beat per cycle while the receiver does not stall: each cell
// of the chain performs up to one CORDIC micro-rotation and one square-root digit,
// and every stage is a single register.
// Reset clears all pipeline valid bits and loads the registers with goal (1.0, 1.0),
// gain 1.0 and speed limit 3.0.
// When the receiver stalls, the output register holds its beat while empty stages
// further up keep filling, so s_ready stays high until every stage holds a beat.
module go_to_goal_velocity_controller_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gtg_pkg::POS_W-1:0]         s_pose_x,
    input  logic [gtg_pkg::POS_W-1:0]         s_pose_y,
    input  logic signed [gtg_pkg::HEAD_W-1:0] s_pose_heading,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gtg_pkg::SPEED_W-1:0]       m_linear_speed,
    output logic [gtg_pkg::TURN_W-1:0]        m_turn_rate,
    input  logic                              cfg_wr_en,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gtg_pkg::CFG_W-1:0]         cfg_wdata
);
    import gtg_pkg::*;

    localparam int N_CELLS  = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int TOTAL    = FRONT_ST + N_CELLS + BACK_ST;
    localparam int TURN_MIN = ((2 << FRAC_BITS) + 5) / 10;

    logic [CFG_W-1:0]    goal_x_reg, goal_y_reg, gain_reg, limit_reg;
    logic [TOTAL-1:0]    vld, hold, en;
    logic                stall;
    logic [FRONT_ST-1:0] front_v;
    logic [BACK_ST-1:0]  back_v;
    logic [N_CELLS:0]    cv;
    cell_data_t          chain [N_CELLS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg <= CFG_W'(4096);
            goal_y_reg <= CFG_W'(4096);
            gain_reg   <= CFG_W'(4096);
            limit_reg  <= CFG_W'(12288);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GOAL_X:      goal_x_reg <= cfg_wdata;
                REG_GOAL_Y:      goal_y_reg <= cfg_wdata;
                REG_SPEED_GAIN:  gain_reg   <= cfg_wdata;
                REG_SPEED_LIMIT: limit_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A stage holds only when it and every stage after it are full and the
    // output beat is not taken.
    assign stall = vld[TOTAL-1] && !m_ready;

    always_comb begin
        for (int k = 0; k < TOTAL; k++) begin
            hold[k] = stall && (&(vld | ((TOTAL'(1) << k) - TOTAL'(1))));
        end
    end

    assign en = ~hold;

    always_comb begin
        vld[FRONT_ST-1:0] = front_v;
        for (int i = 0; i < N_CELLS; i++) begin
            vld[FRONT_ST+i] = cv[i+1];
        end
        vld[TOTAL-1 -: BACK_ST] = back_v;
    end

    gtg_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .en           (en[FRONT_ST-1:0]),
        .goal_x       (goal_x_reg),
        .goal_y       (goal_y_reg),
        .pose_x       (s_pose_x),
        .pose_y       (s_pose_y),
        .pose_heading (s_pose_heading),
        .valid_out    (front_v),
        .out_data     (chain[0])
    );

    assign cv[0] = front_v[FRONT_ST-1];

    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        gtg_cell #(
            .CELL_IDX (i),
            .ROT_EN   ((i < CORDIC_STAGES) ? 1'b1 : 1'b0),
            .SQRT_EN  ((i < SQRT_STEPS) ? 1'b1 : 1'b0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en[FRONT_ST+i]),
            .in_valid  (cv[i]),
            .in_data   (chain[i]),
            .out_valid (cv[i+1]),
            .out_data  (chain[i+1])
        );
    end

    gtg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (cv[N_CELLS]),
        .en           (en[TOTAL-1 -: BACK_ST]),
        .in_data      (chain[N_CELLS]),
        .speed_gain   (gain_reg),
        .speed_limit  (limit_reg),
        .valid_out    (back_v),
        .linear_speed (m_linear_speed),
        .turn_rate    (m_turn_rate)
    );

    assign s_ready = en[0];
    assign m_valid = vld[TOTAL-1];

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output beat valid right after reset");

    a_drive_or_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_linear_speed == '0 || m_turn_rate == '0))
        else $error("speed and turn rate both nonzero");

    a_turn_above_threshold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_turn_rate != '0) |-> (m_turn_rate > TURN_W'(TURN_MIN)))
        else $error("turn rate below the turning threshold");

    a_backpressure_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without an output stall");

endmodule

@@ rtl/core/gtg_front.sv @@
module gtg_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic [gtg_pkg::FRONT_ST-1:0]      en,
    input  logic [gtg_pkg::POS_W-1:0]         goal_x,
    input  logic [gtg_pkg::POS_W-1:0]         goal_y,
    input  logic [gtg_pkg::POS_W-1:0]         pose_x,
    input  logic [gtg_pkg::POS_W-1:0]         pose_y,
    input  logic signed [gtg_pkg::HEAD_W-1:0] pose_heading,
    output logic [gtg_pkg::FRONT_ST-1:0]      valid_out,
    output gtg_pkg::cell_data_t               out_data
);
    import gtg_pkg::*;

    logic [FRONT_ST-1:0]       valid_reg;
    logic [FRONT_ST-1:0]       valid_next;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [DELTA_W-1:0] dx_next, dy_next;
    logic signed [HEAD_W-1:0]  head1_reg, head2_reg;
    logic [VAL_W-1:0]          sqx_reg, sqy_reg;
    logic [VAL_W-1:0]          sqx_next, sqy_next;
    logic signed [VAL_W-1:0]   sqx_s, sqy_s;
    logic signed [XY_W-1:0]    x2_reg, y2_reg;
    logic signed [XY_W-1:0]    x2_next, y2_next;
    logic signed [XY_W-1:0]    xg, yg;
    logic signed [Z_W-1:0]     z2_reg, z2_next;
    cell_data_t                data_reg, data_next;

    always_comb begin
        valid_next[0] = in_valid;
        for (int k = 1; k < FRONT_ST; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    assign dx_next = $signed({1'b0, goal_x}) - $signed({1'b0, pose_x});
    assign dy_next = $signed({1'b0, goal_y}) - $signed({1'b0, pose_y});

    assign sqx_s    = dx_reg * dx_reg;
    assign sqy_s    = dy_reg * dy_reg;
    assign sqx_next = $unsigned(sqx_s);
    assign sqy_next = $unsigned(sqy_s);

    always_comb begin
        xg = XY_W'(dx_reg) <<< GUARD_SH;
        yg = XY_W'(dy_reg) <<< GUARD_SH;
        if (dx_reg < 0) begin
            z2_next = (dy_reg >= 0) ? PI_Q16 : -PI_Q16;
            x2_next = -xg;
            y2_next = -yg;
        end else begin
            z2_next = '0;
            x2_next = xg;
            y2_next = yg;
        end
    end

    always_comb begin
        data_next.x       = x2_reg;
        data_next.y       = y2_reg;
        data_next.z       = z2_reg;
        data_next.rem     = sqx_reg + sqy_reg;
        data_next.root    = '0;
        data_next.heading = head2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < FRONT_ST; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            head1_reg <= pose_heading;
        end
        if (en[1]) begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            z2_reg    <= z2_next;
            head2_reg <= head1_reg;
        end
        if (en[2]) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/gtg_cell.sv @@
module gtg_cell #(
    parameter int CELL_IDX = 0,
    parameter bit ROT_EN   = 1'b1,
    parameter bit SQRT_EN  = 1'b1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  gtg_pkg::cell_data_t in_data,
    output logic                out_valid,
    output gtg_pkg::cell_data_t out_data
);
    import gtg_pkg::*;

    localparam int SQ_B    = SQRT_EN ? (SQRT_STEPS - 1 - CELL_IDX) : 0;
    localparam int TRIAL_W = VAL_W + 1;

    logic                   valid_reg;
    cell_data_t             data_reg, data_next;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  ang;
    logic [TRIAL_W-1:0]     trial;

    assign xs    = in_data.x >>> CELL_IDX;
    assign ys    = in_data.y >>> CELL_IDX;
    assign ang   = atan_q16(ATAN_IDX_W'(CELL_IDX));
    assign trial = (TRIAL_W'(in_data.root) << (SQ_B + 1)) | (TRIAL_W'(1) << (2 * SQ_B));

    always_comb begin
        data_next = in_data;
        if (ROT_EN) begin
            if (in_data.y > 0) begin
                data_next.x = in_data.x + ys;
                data_next.y = in_data.y - xs;
                data_next.z = in_data.z + ang;
            end else begin
                data_next.x = in_data.x - ys;
                data_next.y = in_data.y + xs;
                data_next.z = in_data.z - ang;
            end
        end
        if (SQRT_EN) begin
            if ({1'b0, in_data.rem} >= trial) begin
                data_next.rem  = in_data.rem - trial[VAL_W-1:0];
                data_next.root = in_data.root | (DIST_W'(1) << SQ_B);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/gtg_back.sv @@
module gtg_back #(
    parameter int FRAC_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [gtg_pkg::BACK_ST-1:0]   en,
    input  gtg_pkg::cell_data_t           in_data,
    input  logic [gtg_pkg::CFG_W-1:0]     speed_gain,
    input  logic [gtg_pkg::CFG_W-1:0]     speed_limit,
    output logic [gtg_pkg::BACK_ST-1:0]   valid_out,
    output logic [gtg_pkg::SPEED_W-1:0]   linear_speed,
    output logic [gtg_pkg::TURN_W-1:0]    turn_rate
);
    import gtg_pkg::*;

    localparam int ERR_SH   = ANG_FRAC - FRAC_BITS;
    localparam int ERR_RND  = (ERR_SH == 0) ? 0 : (1 << (ERR_SH - 1));
    localparam int DIST_MIN = ((1 << FRAC_BITS) + 5) / 10;
    localparam int TURN_MIN = ((2 << FRAC_BITS) + 5) / 10;
    localparam int PROD_W   = CFG_W + DIST_W;
    localparam int SPD_HALF = 1 << (FRAC_BITS - 1);

    logic [BACK_ST-1:0]      valid_reg, valid_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;
    logic signed [ERR_W-1:0] err_reg, err_next, err16;
    logic                    near_reg, near_next;
    logic                    spin_reg, spin_next;
    logic [TURN_W-1:0]       tval_reg, tval_next;
    logic [ERR_W-1:0]        aerr;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [PROD_W:0]         spd_sum, spd;
    logic [SPEED_W-1:0]      speed_reg, speed_next;
    logic [TURN_W-1:0]       turn_reg, turn_next;

    always_comb begin
        valid_next[0] = in_valid;
        for (int k = 1; k < BACK_ST; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    assign dist_next = in_data.root +
        DIST_W'(in_data.rem > VAL_W'(in_data.root));
    assign err16     = ERR_W'(in_data.z) - (ERR_W'(in_data.heading) <<< ERR_SH);
    assign err_next  = (err16 + ERR_W'(ERR_RND)) >>> ERR_SH;

    assign aerr      = (err_reg < 0) ? $unsigned(-err_reg) : $unsigned(err_reg);
    assign near_next = (dist_reg <= DIST_W'(DIST_MIN));
    assign spin_next = (aerr > ERR_W'(TURN_MIN));
    assign tval_next = (aerr > ERR_W'(TURN_SAT)) ? TURN_SAT : aerr[TURN_W-1:0];
    assign prod_next = PROD_W'(speed_gain) * PROD_W'(dist_reg);

    always_comb begin
        spd_sum = {1'b0, prod_reg} + (PROD_W + 1)'(SPD_HALF);
        spd     = spd_sum >> FRAC_BITS;
        if (near_reg || spin_reg) begin
            speed_next = '0;
        end else if (spd > (PROD_W + 1)'(speed_limit)) begin
            speed_next = speed_limit;
        end else begin
            speed_next = spd[SPEED_W-1:0];
        end
        turn_next = (!near_reg && spin_reg) ? tval_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < BACK_ST; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dist_reg <= dist_next;
            err_reg  <= err_next;
        end
        if (en[1]) begin
            near_reg <= near_next;
            spin_reg <= spin_next;
            tval_reg <= tval_next;
            prod_reg <= prod_next;
        end
        if (en[2]) begin
            speed_reg <= speed_next;
            turn_reg  <= turn_next;
        end
    end

    assign valid_out    = valid_reg;
    assign linear_speed = speed_reg;
    assign turn_rate    = turn_reg;

endmodule

@@ tb/testbench.sv @@
module testbench;
    import gtg_pkg::*;

    localparam int     FRAC           = 12;
    localparam int     ANGLE_GUARD    = 4;
    localparam int     CORDIC_ITERS   = 16;
    localparam longint HALF_TURN_Q16  = 205887;
    localparam longint STOP_RADIUS    = ((64'sd1 << FRAC) + 5) / 10;
    localparam longint TURN_THRESHOLD = ((64'sd2 << FRAC) + 5) / 10;
    localparam longint TURN_CEILING   = 32767;
    localparam int     PHASES         = 5;
    localparam int     PHASE_POSES    = 240;
    localparam int     DIRECTED_ROWS  = 23;

    typedef struct packed {
        logic [POS_W-1:0]         x;
        logic [POS_W-1:0]         y;
        logic signed [HEAD_W-1:0] heading;
    } pose_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [TURN_W-1:0]  turn;
    } velocity_t;

    typedef struct packed {
        logic [POS_W-1:0]         x;
        logic [POS_W-1:0]         y;
        logic signed [HEAD_W-1:0] heading;
        logic                     typed;
        logic [SPEED_W-1:0]       speed;
        logic [TURN_W-1:0]        turn;
    } stim_row_t;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [POS_W-1:0]          s_pose_x       = '0;
    logic [POS_W-1:0]          s_pose_y       = '0;
    logic signed [HEAD_W-1:0]  s_pose_heading = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [SPEED_W-1:0]        m_linear_speed;
    logic [TURN_W-1:0]         m_turn_rate;
    logic                      cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [CFG_W-1:0]          cfg_wdata      = '0;

    logic [CFG_W-1:0] goal_x_cfg      = 16'd4096;
    logic [CFG_W-1:0] goal_y_cfg      = 16'd4096;
    logic [CFG_W-1:0] speed_gain_cfg  = 16'd4096;
    logic [CFG_W-1:0] speed_limit_cfg = 16'd12288;

    velocity_t pending_cmds [$];
    velocity_t head_cmd;
    int        stall_pct  = 0;
    int        mismatches = 0;
    int        n_poses    = 0;
    int        n_stops    = 0;
    int        n_turns    = 0;
    int        n_drives   = 0;

    longint atan_steps [CORDIC_ITERS] = '{
        51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    // Goal x, goal y, gain, limit for each random phase, extremes included.
    logic [CFG_W-1:0] settings_plan [PHASES][4] = '{
        '{16'd24576, 16'd20480, 16'd4096,  16'd12288},
        '{16'd1,     16'd49151, 16'd65535, 16'd65535},
        '{16'd49151, 16'd1,     16'd0,     16'd40000},
        '{16'd0,     16'd65535, 16'd20000, 16'd0},
        '{16'd32768, 16'd8192,  16'd8192,  16'd65535}
    };
    int sender_idle_plan [PHASES] = '{0, 88, 0, 29, 0};
    int stall_plan       [PHASES] = '{0, 0, 88, 29, 0};

    // Rows with typed results sit at or inside the stop radius of the reset goal.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'd4096,  16'd4096,  15'sd0,       1'b1, 16'd0, 15'd0},
        '{16'd4096,  16'd4096,  -15'sd16384,  1'b1, 16'd0, 15'd0},
        '{16'd4096,  16'd4096,  15'sd16383,   1'b1, 16'd0, 15'd0},
        '{16'd4506,  16'd4096,  15'sd0,       1'b1, 16'd0, 15'd0},
        '{16'd4096,  16'd3686,  15'sd12000,   1'b1, 16'd0, 15'd0},
        '{16'd4507,  16'd4096,  15'sd0,       1'b0, 16'd0, 15'd0},
        '{16'd8192,  16'd4096,  15'sd0,       1'b0, 16'd0, 15'd0},
        '{16'd8192,  16'd4096,  15'sd12868,   1'b0, 16'd0, 15'd0},
        '{16'd0,     16'd4096,  15'sd0,       1'b0, 16'd0, 15'd0},
        '{16'd0,     16'd4096,  15'sd819,     1'b0, 16'd0, 15'd0},
        '{16'd0,     16'd4096,  15'sd820,     1'b0, 16'd0, 15'd0},
        '{16'd0,     16'd4096,  -15'sd819,    1'b0, 16'd0, 15'd0},
        '{16'd0,     16'd4096,  -15'sd820,    1'b0, 16'd0, 15'd0},
        '{16'd0,     16'd0,     15'sd3217,    1'b0, 16'd0, 15'd0},
        '{16'd0,     16'd0,     -15'sd16384,  1'b0, 16'd0, 15'd0},
        '{16'd65535, 16'd65535, 15'sd16383,   1'b0, 16'd0, 15'd0},
        '{16'd65535, 16'd0,     -15'sd16384,  1'b0, 16'd0, 15'd0},
        '{16'd0,     16'd65535, 15'sd16383,   1'b0, 16'd0, 15'd0},
        '{16'd4096,  16'd0,     15'sd6434,    1'b0, 16'd0, 15'd0},
        '{16'd4096,  16'd8192,  -15'sd6434,   1'b0, 16'd0, 15'd0},
        '{16'd16384, 16'd4096,  15'sd12868,   1'b0, 16'd0, 15'd0},
        '{16'd20480, 16'd4096,  15'sd12868,   1'b0, 16'd0, 15'd0},
        '{16'd49151, 16'd49151, -15'sd9651,   1'b0, 16'd0, 15'd0}
    };

    go_to_goal_velocity_controller_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pose_x       (s_pose_x),
        .s_pose_y       (s_pose_y),
        .s_pose_heading (s_pose_heading),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_linear_speed (m_linear_speed),
        .m_turn_rate    (m_turn_rate),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial forever #2 aclk = ~aclk;

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint unsigned isqrt_round(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        longint unsigned rest;
        root = 0;
        bitv = 64'd1 << 62;
        rest = v;
        while (bitv > rest) bitv >>= 2;
        while (bitv != 0) begin
            if (rest >= root + bitv) begin
                rest -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        if (rest > root) root++;
        return root;
    endfunction

    function automatic longint bearing_q16(input longint dx, input longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += atan_steps[i];
            end else begin
                x -= ys;
                y += xs;
                z -= atan_steps[i];
            end
        end
        return z;
    endfunction

    function automatic longint heading_to_goal(input logic [POS_W-1:0] x,
                                               input logic [POS_W-1:0] y);
        return (bearing_q16(longint'(goal_x_cfg) - longint'(x),
                            longint'(goal_y_cfg) - longint'(y)) + 8) >>> ANGLE_GUARD;
    endfunction

    function automatic velocity_t predict_command(input pose_t p);
        longint          dx;
        longint          dy;
        longint          err;
        longint          abs_err;
        longint unsigned range_q;
        longint unsigned speed;
        velocity_t       cmd;
        dx = longint'(goal_x_cfg) - longint'(p.x);
        dy = longint'(goal_y_cfg) - longint'(p.y);
        range_q = isqrt_round(dx * dx + dy * dy);
        err = (bearing_q16(dx, dy) - longint'(p.heading) * (64'sd1 << ANGLE_GUARD) + 8)
              >>> ANGLE_GUARD;
        abs_err = (err < 0) ? -err : err;
        cmd = '0;
        if (range_q > STOP_RADIUS) begin
            if (abs_err > TURN_THRESHOLD) begin
                cmd.turn = TURN_W'((abs_err > TURN_CEILING) ? TURN_CEILING : abs_err);
            end else begin
                speed = (speed_gain_cfg * range_q + (64'd1 << (FRAC - 1))) >> FRAC;
                if (speed > speed_limit_cfg) speed = speed_limit_cfg;
                cmd.speed = SPEED_W'(speed);
            end
        end
        return cmd;
    endfunction

    // The largest share of poses aim near the goal bearing so the drive and threshold paths
    // are hit; the rest are near-goal poses and fully random ones.
    function automatic pose_t draw_pose();
        pose_t  p;
        int     pick;
        longint aim;
        pick = $urandom_range(99);
        p.x = POS_W'($urandom);
        p.y = POS_W'($urandom);
        p.heading = HEAD_W'($urandom);
        if (pick < 15) begin
            p.x = POS_W'(int'(goal_x_cfg) + int'($urandom_range(1000)) - 500);
            p.y = POS_W'(int'(goal_y_cfg) + int'($urandom_range(1000)) - 500);
        end else if (pick < 60) begin
            aim = heading_to_goal(p.x, p.y) + longint'($urandom_range(2000)) - 1000;
            if (aim > 16383) aim = 16383;
            if (aim < -16384) aim = -16384;
            p.heading = HEAD_W'(aim);
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic send_pose(input pose_t p, input velocity_t want, input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid        <= 1'b1;
        s_pose_x       <= p.x;
        s_pose_y       <= p.y;
        s_pose_heading <= p.heading;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_cmds.push_back(want);
        n_poses++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_cmds.size() != 0) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] vals [4]);
        logic [CFG_IDX_W-1:0] regs [4];
        regs = '{REG_GOAL_X, REG_GOAL_Y, REG_SPEED_GAIN, REG_SPEED_LIMIT};
        for (int r = 0; r < 4; r++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[r];
            cfg_wdata <= vals[r];
            @(posedge aclk);
        end
        cfg_wr_en       <= 1'b0;
        goal_x_cfg      = vals[0];
        goal_y_cfg      = vals[1];
        speed_gain_cfg  = vals[2];
        speed_limit_cfg = vals[3];
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                report_mismatch("result beat with no pose pending");
            end else begin
                head_cmd = pending_cmds.pop_front();
                if (m_linear_speed !== head_cmd.speed)
                    report_mismatch($sformatf("linear_speed got %0d want %0d",
                                              m_linear_speed, head_cmd.speed));
                if (m_turn_rate !== head_cmd.turn)
                    report_mismatch($sformatf("turn_rate got %0d want %0d",
                                              m_turn_rate, head_cmd.turn));
                if (head_cmd.turn != 0) n_turns++;
                else if (head_cmd.speed != 0) n_drives++;
                else n_stops++;
            end
        end
    end

    initial begin
        pose_t     p;
        velocity_t want;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            p = '{directed_rows[i].x, directed_rows[i].y, directed_rows[i].heading};
            if (directed_rows[i].typed)
                want = '{directed_rows[i].speed, directed_rows[i].turn};
            else
                want = predict_command(p);
            send_pose(p, want, 0);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            load_settings(settings_plan[ph]);
            stall_pct = stall_plan[ph];
            for (int n = 0; n < PHASE_POSES; n++) begin
                // The sender holds off once until the pipeline is empty.
                if (ph == 2 && n == PHASE_POSES / 2) drain();
                p = draw_pose();
                send_pose(p, predict_command(p), sender_idle_plan[ph]);
            end
        end

        drain();
        repeat (40) @(posedge aclk);

        $display("Sent %0d poses over the reset goal and %0d register settings,",
                 n_poses, PHASES);
        $display("with %0d stops, %0d turns in place and %0d forward drives checked.",
                 n_stops, n_turns, n_drives);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/gtg_pkg.sv
rtl/core/gtg_front.sv
rtl/core/gtg_cell.sv
rtl/core/gtg_back.sv
rtl/core/go_to_goal_velocity_controller_unit.sv
tb/testbench.sv
